@@ rtl/core/cdq_pkg.sv @@
// shared types and constants of the circular deque
package cdq_pkg;

  localparam int unsigned DEPTH_DEF = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OCC_W     = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_REAR  = 2'd0,
    MODE_PUSH_FRONT = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_REAR   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // what one cell does with its word in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_SHR   = 2'd2,
    CELL_SHL   = 2'd3
  } cell_op_e;

endpackage

@@ rtl/core/cdq_if.sv @@
// operation and result channels of the circular deque
interface cdq_in_if import cdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [WORD_W-1:0] data_in;

  modport source (output valid, mode, data_in, input ready);
  modport sink (input valid, mode, data_in, output ready);
endinterface

interface cdq_out_if import cdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] data_out;
  logic [STATUS_W-1:0]      status;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, data_out, status, occupancy, input ready);
  modport sink (input valid, data_out, status, occupancy, output ready);
endinterface

@@ rtl/core/circular_deque.sv @@
// an accepted operation's result is registered, shown in the next cycle
// throughput: one operation per cycle while results are taken; on a push or
//   pop at the front all cells shift at once; front always sits in cell zero
// reset: the fill count clears at once and the deque is empty; cell contents
//   are left as they are and never read before written
module circular_deque import cdq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  cdq_in_if.sink    in_i,
  cdq_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]          count_q, count_d;
  logic                     out_valid_q;
  logic signed [WORD_W-1:0] data_out_q, data_out_d;
  status_e                  status_q, status_d;
  logic [OCC_W-1:0]         occ_q;

  logic                     accept;
  logic                     full, empty;
  mode_e                    mode;
  cell_op_e                 cell_op [DEPTH];
  logic signed [WORD_W-1:0] cell_word [DEPTH];
  logic signed [WORD_W-1:0] rear_word;

  assign mode     = mode_e'(in_i.mode);
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept   = in_i.valid && in_i.ready;
  assign full     = (count_q == CntW'(DEPTH));
  assign empty    = (count_q == '0);

  // per cell control
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
      if (accept) begin
        case (mode)
          MODE_PUSH_REAR:  if (!full && count_q == CntW'(i)) cell_op[i] = CELL_LOAD;
          MODE_PUSH_FRONT: if (!full) cell_op[i] = CELL_SHR;
          MODE_POP_FRONT:  if (!empty) cell_op[i] = CELL_SHL;
          default:         cell_op[i] = CELL_HOLD;
        endcase
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : gen_cell
    logic signed [WORD_W-1:0] left_w, right_w;
    if (g == 0) begin : gen_first
      assign left_w = in_i.data_in;
    end else begin : gen_mid_l
      assign left_w = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : gen_last
      assign right_w = in_i.data_in;
    end else begin : gen_mid_r
      assign right_w = cell_word[g+1];
    end
    cdq_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[g]),
      .load_i  (in_i.data_in),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (cell_word[g])
    );
  end

  // rear word sits in the cell just below the fill count
  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (count_q == CntW'(i + 1)) rear_word = rear_word | cell_word[i];
    end
  end

  always_comb begin
    count_d    = count_q;
    data_out_d = '0;
    status_d   = ST_OK;
    case (mode)
      MODE_PUSH_REAR, MODE_PUSH_FRONT: begin
        if (full) status_d = ST_OVERFLOW;
        else count_d = count_q + CntW'(1);
      end
      MODE_POP_FRONT: begin
        if (empty) status_d = ST_UNDERFLOW;
        else begin
          data_out_d = cell_word[0];
          count_d    = count_q - CntW'(1);
        end
      end
      default: begin
        if (empty) status_d = ST_UNDERFLOW;
        else begin
          data_out_d = rear_word;
          count_d    = count_q - CntW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) count_q <= count_d;
      if (accept) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_out_q <= data_out_d;
      status_q   <= status_d;
      occ_q      <= OCC_W'(count_d);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.data_out  = data_out_q;
  assign out_o.status    = status_q;
  assign out_o.occupancy = occ_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count beyond depth");

  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full && (mode == MODE_PUSH_REAR || mode == MODE_PUSH_FRONT)
    |=> out_o.valid && out_o.status == ST_OVERFLOW && $stable(count_q))
    else $error("push on full deque not flagged");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !empty && (mode == MODE_POP_FRONT || mode == MODE_POP_REAR)
    |=> count_q + CntW'(1) == $past(count_q) && out_o.status == ST_OK)
    else $error("pop did not drop the fill count");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted operation gave no result");

endmodule

@@ rtl/core/cdq_cell.sv @@
// one storage cell of the deque row
module cdq_cell import cdq_pkg::*; (
  input  logic                     clk_i,
  input  cell_op_e                 op_i,
  input  logic signed [WORD_W-1:0] load_i,
  input  logic signed [WORD_W-1:0] left_i,
  input  logic signed [WORD_W-1:0] right_i,
  output logic signed [WORD_W-1:0] word_o
);

  logic signed [WORD_W-1:0] word_q;
  logic signed [WORD_W-1:0] word_d;

  always_comb begin
    case (op_i)
      CELL_LOAD: word_d = load_i;
      CELL_SHR:  word_d = left_i;
      CELL_SHL:  word_d = right_i;
      default:   word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule
